[rtl/hdk_pkg.sv]
// Shared types, constants and key tables for the two-set keystroke converter.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package hdk_pkg;

	localparam logic [15:0] SYL_FIRST  = 16'hAC00;
	localparam logic [15:0] SYL_LAST   = 16'hD7A3;
	localparam logic [15:0] JAMO_FIRST = 16'h3131;
	localparam logic [15:0] JAMO_LAST  = 16'h3163;

	// Reciprocals for the two constant divisions, with enough fraction bits
	// that the truncated product is exact over the syllable range.
	localparam int          DIV588_SHIFT = 24;
	localparam logic [14:0] DIV588_RECIP = 15'd28533;
	localparam logic [13:0] PER_INITIAL  = 14'd588;
	localparam int          DIV28_SHIFT  = 16;
	localparam logic [11:0] DIV28_RECIP  = 12'd2341;
	localparam logic [9:0]  FINAL_COUNT  = 10'd28;

	localparam int          MAX_CHARS = 5;
	localparam logic [7:0]  NO_KEY    = 8'h00;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_SYL,
		KIND_JAMO
	} kind_t;

	// Decoded fields of one code unit as it travels down the pipeline.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] cu;
		logic [5:0]  jidx;
		logic [4:0]  ini;
		logic [4:0]  med;
		logic [4:0]  fin;
	} item_t;

	// One run of output characters, left aligned, with its length.
	typedef struct packed {
		logic [2:0]                  count;
		logic [MAX_CHARS-1:0][15:0]  chars;
	} run_t;

	// Pair tables return {first, second}; NO_KEY marks an empty slot.
	function automatic logic [7:0] initial_key(input logic [4:0] idx);
		logic [7:0] k;
		unique case (idx)
			5'd0:  k = "r";
			5'd1:  k = "R";
			5'd2:  k = "s";
			5'd3:  k = "e";
			5'd4:  k = "E";
			5'd5:  k = "f";
			5'd6:  k = "a";
			5'd7:  k = "q";
			5'd8:  k = "Q";
			5'd9:  k = "t";
			5'd10: k = "T";
			5'd11: k = "d";
			5'd12: k = "w";
			5'd13: k = "W";
			5'd14: k = "c";
			5'd15: k = "z";
			5'd16: k = "x";
			5'd17: k = "v";
			5'd18: k = "g";
			default: k = NO_KEY;
		endcase
		return k;
	endfunction

	function automatic logic [15:0] medial_keys(input logic [4:0] idx);
		logic [15:0] k;
		unique case (idx)
			5'd0:  k = {"k", NO_KEY};
			5'd1:  k = {"o", NO_KEY};
			5'd2:  k = {"i", NO_KEY};
			5'd3:  k = {"O", NO_KEY};
			5'd4:  k = {"j", NO_KEY};
			5'd5:  k = {"p", NO_KEY};
			5'd6:  k = {"u", NO_KEY};
			5'd7:  k = {"P", NO_KEY};
			5'd8:  k = {"h", NO_KEY};
			5'd9:  k = {"h", "k"};
			5'd10: k = {"h", "o"};
			5'd11: k = {"h", "l"};
			5'd12: k = {"y", NO_KEY};
			5'd13: k = {"n", NO_KEY};
			5'd14: k = {"n", "j"};
			5'd15: k = {"n", "p"};
			5'd16: k = {"n", "l"};
			5'd17: k = {"b", NO_KEY};
			5'd18: k = {"m", NO_KEY};
			5'd19: k = {"m", "l"};
			5'd20: k = {"l", NO_KEY};
			default: k = {NO_KEY, NO_KEY};
		endcase
		return k;
	endfunction

	function automatic logic [15:0] final_keys(input logic [4:0] idx);
		logic [15:0] k;
		unique case (idx)
			5'd1:  k = {"r", NO_KEY};
			5'd2:  k = {"R", NO_KEY};
			5'd3:  k = {"r", "t"};
			5'd4:  k = {"s", NO_KEY};
			5'd5:  k = {"s", "w"};
			5'd6:  k = {"s", "g"};
			5'd7:  k = {"e", NO_KEY};
			5'd8:  k = {"f", NO_KEY};
			5'd9:  k = {"f", "r"};
			5'd10: k = {"f", "a"};
			5'd11: k = {"f", "q"};
			5'd12: k = {"f", "t"};
			5'd13: k = {"f", "x"};
			5'd14: k = {"f", "v"};
			5'd15: k = {"f", "g"};
			5'd16: k = {"a", NO_KEY};
			5'd17: k = {"q", NO_KEY};
			5'd18: k = {"q", "t"};
			5'd19: k = {"t", NO_KEY};
			5'd20: k = {"T", NO_KEY};
			5'd21: k = {"d", NO_KEY};
			5'd22: k = {"w", NO_KEY};
			5'd23: k = {"c", NO_KEY};
			5'd24: k = {"z", NO_KEY};
			5'd25: k = {"x", NO_KEY};
			5'd26: k = {"v", NO_KEY};
			5'd27: k = {"g", NO_KEY};
			default: k = {NO_KEY, NO_KEY};
		endcase
		return k;
	endfunction

	function automatic logic [15:0] jamo_keys(input logic [5:0] idx);
		logic [15:0] k;
		unique case (idx)
			6'd0:  k = {"r", NO_KEY};
			6'd1:  k = {"R", NO_KEY};
			6'd2:  k = {"r", "t"};
			6'd3:  k = {"s", NO_KEY};
			6'd4:  k = {"s", "w"};
			6'd5:  k = {"s", "g"};
			6'd6:  k = {"e", NO_KEY};
			6'd7:  k = {"E", NO_KEY};
			6'd8:  k = {"f", NO_KEY};
			6'd9:  k = {"f", "r"};
			6'd10: k = {"f", "a"};
			6'd11: k = {"f", "q"};
			6'd12: k = {"f", "t"};
			6'd13: k = {"f", "x"};
			6'd14: k = {"f", "v"};
			6'd15: k = {"f", "g"};
			6'd16: k = {"a", NO_KEY};
			6'd17: k = {"q", NO_KEY};
			6'd18: k = {"Q", NO_KEY};
			6'd19: k = {"q", "t"};
			6'd20: k = {"t", NO_KEY};
			6'd21: k = {"T", NO_KEY};
			6'd22: k = {"d", NO_KEY};
			6'd23: k = {"w", NO_KEY};
			6'd24: k = {"W", NO_KEY};
			6'd25: k = {"c", NO_KEY};
			6'd26: k = {"z", NO_KEY};
			6'd27: k = {"x", NO_KEY};
			6'd28: k = {"v", NO_KEY};
			6'd29: k = {"g", NO_KEY};
			6'd30: k = {"k", NO_KEY};
			6'd31: k = {"o", NO_KEY};
			6'd32: k = {"i", NO_KEY};
			6'd33: k = {"O", NO_KEY};
			6'd34: k = {"j", NO_KEY};
			6'd35: k = {"p", NO_KEY};
			6'd36: k = {"u", NO_KEY};
			6'd37: k = {"P", NO_KEY};
			6'd38: k = {"h", NO_KEY};
			6'd39: k = {"h", "k"};
			6'd40: k = {"h", "o"};
			6'd41: k = {"h", "l"};
			6'd42: k = {"y", NO_KEY};
			6'd43: k = {"n", NO_KEY};
			6'd44: k = {"n", "j"};
			6'd45: k = {"n", "p"};
			6'd46: k = {"n", "l"};
			6'd47: k = {"b", NO_KEY};
			6'd48: k = {"m", NO_KEY};
			6'd49: k = {"m", "l"};
			6'd50: k = {"l", NO_KEY};
			default: k = {NO_KEY, NO_KEY};
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[rtl/hdk_split.sv]
// Five-stage pipeline that classifies a code unit and splits a syllable into
// initial, medial and final indices by reciprocal multiplication. Uses hdk_pkg.
`default_nettype none

module hdk_split import hdk_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [15:0] in_code,
	output logic             in_ready,
	output logic             out_valid,
	output item_t            out_item,
	input  wire logic        out_ready
);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        rdy1, rdy2, rdy3, rdy4, rdy5;
	item_t       item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [13:0] syl_s1, syl_s2;
	logic [9:0]  rem_s3, rem_s4;

	kind_t       kind_d;
	logic [15:0] syl_diff;
	logic [15:0] jamo_diff;
	logic [28:0] ini_prod;
	logic [13:0] ini_back;
	logic [13:0] rem_full;
	logic [20:0] med_prod;
	logic [9:0]  med_back;
	logic [9:0]  fin_full;
	item_t       item_d2, item_d4, item_d5;

	// A stage takes new data when it is empty or its successor moves on.
	assign rdy5 = !v_s5 || out_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready  = rdy1;
	assign out_valid = v_s5;
	assign out_item  = item_s5;

	always_comb begin
		priority if (in_code >= SYL_FIRST && in_code <= SYL_LAST) begin
			kind_d = KIND_SYL;
		end else if (in_code >= JAMO_FIRST && in_code <= JAMO_LAST) begin
			kind_d = KIND_JAMO;
		end else begin
			kind_d = KIND_OTHER;
		end
	end

	assign syl_diff  = in_code - SYL_FIRST;
	assign jamo_diff = in_code - JAMO_FIRST;

	assign ini_prod = {15'd0, syl_s1} * {14'd0, DIV588_RECIP};
	assign ini_back = {9'd0, item_s2.ini} * PER_INITIAL;
	assign rem_full = syl_s2 - ini_back;
	assign med_prod = {11'd0, rem_s3} * {9'd0, DIV28_RECIP};
	assign med_back = {5'd0, item_s4.med} * FINAL_COUNT;
	assign fin_full = rem_s4 - med_back;

	always_comb begin
		item_d2     = item_s1;
		item_d2.ini = ini_prod[DIV588_SHIFT +: 5];
		item_d4     = item_s3;
		item_d4.med = med_prod[DIV28_SHIFT +: 5];
		item_d5     = item_s4;
		item_d5.fin = fin_full[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			item_s1.kind <= kind_d;
			item_s1.cu   <= in_code;
			item_s1.jidx <= jamo_diff[5:0];
			item_s1.ini  <= 5'd0;
			item_s1.med  <= 5'd0;
			item_s1.fin  <= 5'd0;
			syl_s1       <= syl_diff[13:0];
		end
		if (rdy2) begin
			item_s2 <= item_d2;
			syl_s2  <= syl_s1;
		end
		if (rdy3) begin
			item_s3 <= item_s2;
			rem_s3  <= rem_full[9:0];
		end
		if (rdy4) begin
			item_s4 <= item_d4;
			rem_s4  <= rem_s3;
		end
		if (rdy5) begin
			item_s5 <= item_d5;
		end
	end

endmodule

`default_nettype wire

[rtl/hdk_pack.sv]
// Pipeline stage that looks up the key tables and packs the run of output
// characters left aligned with its length. Uses hdk_pkg.
`default_nettype none

module hdk_pack import hdk_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire item_t in_item,
	output logic       in_ready,
	output logic       out_valid,
	output run_t       out_run,
	input  wire logic  out_ready
);

	logic       v_s6;
	run_t       run_s6;
	run_t       run_d;
	logic [15:0] med_pair;
	logic [15:0] fin_pair;
	logic [15:0] jamo_pair;
	logic [2:0]  fin_base;

	assign in_ready  = !v_s6 || out_ready;
	assign out_valid = v_s6;
	assign out_run   = run_s6;

	assign med_pair  = medial_keys(in_item.med);
	assign fin_pair  = final_keys(in_item.fin);
	assign jamo_pair = jamo_keys(in_item.jidx);

	always_comb begin
		run_d.count = 3'd1;
		run_d.chars = '0;
		fin_base    = (med_pair[7:0] != NO_KEY) ? 3'd3 : 3'd2;
		unique case (in_item.kind)
			KIND_SYL: begin
				run_d.chars[0] = {8'd0, initial_key(in_item.ini)};
				run_d.chars[1] = {8'd0, med_pair[15:8]};
				if (med_pair[7:0] != NO_KEY) begin
					run_d.chars[2] = {8'd0, med_pair[7:0]};
				end
				run_d.count = fin_base;
				// A syllable without a final consonant stops after the vowel.
				if (fin_pair[15:8] != NO_KEY) begin
					run_d.chars[fin_base] = {8'd0, fin_pair[15:8]};
					run_d.count = fin_base + 3'd1;
					if (fin_pair[7:0] != NO_KEY) begin
						run_d.chars[fin_base + 3'd1] = {8'd0, fin_pair[7:0]};
						run_d.count = fin_base + 3'd2;
					end
				end
			end
			KIND_JAMO: begin
				run_d.chars[0] = {8'd0, jamo_pair[15:8]};
				if (jamo_pair[7:0] != NO_KEY) begin
					run_d.chars[1] = {8'd0, jamo_pair[7:0]};
					run_d.count = 3'd2;
				end
			end
			default: begin
				run_d.chars[0] = in_item.cu;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (in_ready) begin
			v_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			run_s6 <= run_d;
		end
	end

endmodule

`default_nettype wire

[rtl/hdk_emit.sv]
// Serializer that holds one packed run and presents its characters one per
// cycle, loading the next run in the cycle of the last one. Uses hdk_pkg.
`default_nettype none

module hdk_emit import hdk_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire run_t   in_run,
	output logic        in_ready,
	output logic        result_valid,
	output logic [15:0] out_char,
	output logic        last_of_run
);

	logic       valid_q;
	run_t       run_q;
	logic [2:0] idx_q;
	logic       at_last;

	assign at_last      = (idx_q == run_q.count - 3'd1);
	assign in_ready     = !valid_q || at_last;
	assign result_valid = valid_q;
	assign out_char     = run_q.chars[idx_q];
	assign last_of_run  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			idx_q   <= 3'd0;
		end else begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			run_q <= in_run;
		end
	end

endmodule

`default_nettype wire

[rtl/hangul_to_dubeolsik_keys_unit.sv]
// Top level of the Hangul to two-set keystroke converter.
// Instantiates hdk_split, hdk_pack and hdk_emit; uses hdk_pkg.
//
// Channel   Ports                                     Handshake
// input     start, busy, code_unit[15:0]              word taken when start && !busy
// result    result_valid, out_char[15:0], last_of_run one word per strobe cycle
//
// A code unit enters the six-stage pipeline in any cycle that busy is low.
// Each word yields one to five result words, one per cycle; the output
// serializer sets that rate. The first result reaches the ports after the
// word has passed hdk_split, hdk_pack and the serializer's run register.
// The receiver cannot stall; busy rises only while the serializer works
// through a run and every stage behind it holds an item.
`default_nettype none

module hangul_to_dubeolsik_keys_unit import hdk_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] code_unit,
	output logic             result_valid,
	output logic [15:0]      out_char,
	output logic             last_of_run
);

	logic  split_ready;
	logic  split_valid;
	item_t split_item;
	logic  pack_ready;
	logic  pack_valid;
	run_t  pack_run;
	logic  emit_ready;

	assign busy = !split_ready;

	hdk_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_code   (code_unit),
		.in_ready  (split_ready),
		.out_valid (split_valid),
		.out_item  (split_item),
		.out_ready (pack_ready)
	);

	hdk_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_item   (split_item),
		.in_ready  (pack_ready),
		.out_valid (pack_valid),
		.out_run   (pack_run),
		.out_ready (emit_ready)
	);

	hdk_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pack_valid),
		.in_run       (pack_run),
		.in_ready     (emit_ready),
		.result_valid (result_valid),
		.out_char     (out_char),
		.last_of_run  (last_of_run)
	);

`ifndef SYNTHESIS
	// A run that has not ended continues in the next cycle.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |=> result_valid)
		else $error("result run broken before its last word");

	// Only key letters appear before the end of a multi-word run.
	a_inner_is_key: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |-> out_char[15:8] == 8'h00)
		else $error("non-key word inside a run");

	// Input back-pressure only comes from a serializer in mid-run.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> result_valid && !last_of_run)
		else $error("busy without a run in progress");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for hangul_to_dubeolsik_keys_unit: predicts the two-set key run
// of every accepted word and checks each result word against it. Depends on hdk_pkg.
`timescale 1ns / 1ps

module tb_top;
	import hdk_pkg::*;

	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_WORDS = 250;

	typedef struct {
		logic [15:0] ch;
		logic        last;
	} key_word_t;

	class keystroke_checker;
		localparam int FINALS    = 28;
		localparam int PER_LEAD  = 21 * 28;

		key_word_t pending_keys[$];
		int        failures;

		string lead_keys = "rRseEfaqQtTdwWczxvg";
		string vowel_keys[21] = '{"k", "o", "i", "O", "j", "p", "u", "P", "h", "hk", "ho",
			"hl", "y", "n", "nj", "np", "nl", "b", "m", "ml", "l"};
		string tail_keys[28] = '{"", "r", "R", "rt", "s", "sw", "sg", "e", "f", "fr", "fa",
			"fq", "ft", "fx", "fv", "fg", "a", "q", "qt", "t", "T", "d", "w", "c", "z", "x",
			"v", "g"};
		string compat_keys[51] = '{"r", "R", "rt", "s", "sw", "sg", "e", "E", "f", "fr",
			"fa", "fq", "ft", "fx", "fv", "fg", "a", "q", "Q", "qt", "t", "T", "d", "w", "W",
			"c", "z", "x", "v", "g", "k", "o", "i", "O", "j", "p", "u", "P", "h", "hk", "ho",
			"hl", "y", "n", "nj", "np", "nl", "b", "m", "ml", "l"};

		function new();
			failures = 0;
		endfunction

		function int pending();
			return pending_keys.size();
		endfunction

		// Expands one code unit into its key run and queues the words in order.
		function void note_code_unit(logic [15:0] cu);
			string       keys;
			int          s;
			logic [15:0] run[$];
			key_word_t   w;
			keys = "";
			if (cu >= SYL_FIRST && cu <= SYL_LAST) begin
				s = int'(cu - SYL_FIRST);
				keys = {keys, lead_keys.substr(s / PER_LEAD, s / PER_LEAD)};
				keys = {keys, vowel_keys[(s % PER_LEAD) / FINALS]};
				keys = {keys, tail_keys[s % FINALS]};
			end else if (cu >= JAMO_FIRST && cu <= JAMO_LAST) begin
				keys = compat_keys[int'(cu - JAMO_FIRST)];
			end
			for (int i = 0; i < keys.len(); i++)
				run.push_back({8'h00, keys[i]});
			if (run.size() == 0)
				run.push_back(cu);
			foreach (run[i]) begin
				w.ch   = run[i];
				w.last = (i == run.size() - 1);
				pending_keys.push_back(w);
			end
		endfunction

		function void check_char(logic [15:0] ch, logic last);
			key_word_t w;
			if (pending_keys.size() == 0) begin
				$error("result word %h (last_of_run %b) with nothing expected", ch, last);
				failures++;
				return;
			end
			w = pending_keys.pop_front();
			if (ch !== w.ch) begin
				$error("out_char: expected %h, got %h", w.ch, ch);
				failures++;
			end
			if (last !== w.last) begin
				$error("last_of_run: expected %b, got %b", w.last, last);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] code_unit = '0;
	logic        busy;
	logic        result_valid;
	logic [15:0] out_char;
	logic        last_of_run;

	keystroke_checker keys_sb = new();
	int idle_cycles = 0;

	hangul_to_dubeolsik_keys_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.code_unit    (code_unit),
		.result_valid (result_valid),
		.out_char     (out_char),
		.last_of_run  (last_of_run)
	);

	always #10 clk = ~clk;

	// Both channels are sampled at the edge, before any nonblocking update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				keys_sb.note_code_unit(code_unit);
			if (result_valid)
				keys_sb.check_char(out_char, last_of_run);
			if ((start && !busy) || result_valid)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] syllable(int ini, int med, int fin);
		return SYL_FIRST + 16'(ini * 588 + med * 28 + fin);
	endfunction

	// Holds start until the word is taken, then optionally idles for gap cycles.
	task automatic send_word(input logic [15:0] cu, input int gap);
		start     <= 1'b1;
		code_unit <= cu;
		do
			@(posedge clk);
		while (busy);
		if (gap > 0) begin
			start     <= 1'b0;
			code_unit <= 16'($urandom());
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] random_word();
		int          kind;
		logic [15:0] base;
		int          dbl_med[7] = '{9, 10, 11, 14, 15, 16, 19};
		int          dbl_fin[11] = '{3, 5, 6, 9, 10, 11, 12, 13, 14, 15, 18};
		kind = $urandom_range(0, 19);
		if (kind < 8)
			return syllable($urandom_range(0, 18), $urandom_range(0, 20), $urandom_range(0, 27));
		if (kind < 11)
			return syllable($urandom_range(0, 18), dbl_med[$urandom_range(0, 6)],
				dbl_fin[$urandom_range(0, 10)]);
		if (kind < 12)
			return syllable($urandom_range(0, 18), $urandom_range(0, 20), 0);
		if (kind < 15)
			return JAMO_FIRST + 16'($urandom_range(0, 50));
		if (kind < 17) begin
			case ($urandom_range(0, 3))
				0: base = SYL_FIRST;
				1: base = SYL_LAST;
				2: base = JAMO_FIRST;
				default: base = JAMO_LAST;
			endcase
			return base + 16'($urandom_range(0, 4)) - 16'd2;
		end
		return 16'($urandom());
	endfunction

	initial begin
		logic [15:0] directed[$];
		bit          no_gaps;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Range edges, all-zero and all-one words, surrogates, and the longest runs.
		directed = '{16'h0000, 16'hFFFF, SYL_FIRST, SYL_LAST, SYL_FIRST - 16'd1,
			SYL_LAST + 16'd1, JAMO_FIRST, JAMO_LAST, JAMO_FIRST - 16'd1, JAMO_LAST + 16'd1,
			syllable(0, 9, 3), syllable(18, 19, 18), syllable(0, 9, 0), syllable(18, 20, 0),
			syllable(10, 16, 27), JAMO_FIRST + 16'd2, JAMO_FIRST + 16'd39, 16'hD800,
			16'hDFFF, 16'h0041, 16'h8000, 16'h5555, 16'hAAAA, 16'hFFFE, 16'h7FFF};
		foreach (directed[i])
			send_word(directed[i], (i < 12) ? 0 : pick_gap());

		no_gaps = 1'b0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			send_word(random_word(), no_gaps ? 0 : pick_gap());
		end
		start <= 1'b0;

		while (keys_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (keys_sb.failures == 0 && keys_sb.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
